/* src/sparse_image_chunk_splitter_core_defines.svh */
// ----------------------------------------------------------------------------
// Sparse image chunk splitter assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SPARSE_IMAGE_CHUNK_SPLITTER_CORE_DEFINES_SVH
`define SPARSE_IMAGE_CHUNK_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SISC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SISC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sisc_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse image chunk splitter package
// Shared types, codes and sizes for the splitter core.
// ----------------------------------------------------------------------------
package sisc_pkg;

    // entry list sizing
    localparam int unsigned MAX_ENTRIES = 65536;
    localparam int unsigned ENTRY_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // chunk type codes
    localparam logic [1:0] SEG_RAW  = 2'd0;
    localparam logic [1:0] SEG_FILL = 2'd1;
    localparam logic [1:0] SEG_SKIP = 2'd2;

    // payload source codes
    localparam logic [1:0] SRC_ENTRIES  = 2'd0;
    localparam logic [1:0] SRC_ORIGINAL = 2'd1;
    localparam logic [1:0] SRC_NONE     = 2'd2;

    // header and fill payload sizes
    localparam logic [7:0] DEFAULT_HEADER_BYTES = 8'd12;
    localparam logic [2:0] FILL_PAYLOAD_BYTES   = 3'd4;
    localparam logic [20:0] DEFAULT_BLOCK_BYTES = 21'd4096;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_BLOCK = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINAL_BLOCK = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHUNK_KIND  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_LEN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BYTES = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DATA_OFFSET = 3'd5;

    // command queue sizing
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam logic [QUEUE_PTR_W:0] QUEUE_FULL_COUNT = (QUEUE_PTR_W+1)'(QUEUE_DEPTH);

    // configuration set
    typedef struct packed {
        logic [31:0] first_block;
        logic [31:0] final_block;
        logic [1:0]  kind;
        logic [7:0]  header_bytes;
        logic [20:0] bytes_per_block;
        logic [47:0] data_offset;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        first_block:     32'd0,
        final_block:     32'd0,
        kind:            SEG_RAW,
        header_bytes:    DEFAULT_HEADER_BYTES,
        bytes_per_block: DEFAULT_BLOCK_BYTES,
        data_offset:     48'd0
    };

    // descriptor command from front to back
    typedef struct packed {
        logic [1:0]  seg_type;
        logic [1:0]  src;
        logic [31:0] count;
        logic [32:0] blocks_in;
        logic [15:0] first_idx;
        logic [31:0] seg_index;
        logic        last_result;
        logic        final_segment;
    } t_cmd;

    // finished descriptor
    typedef struct packed {
        logic [1:0]  seg_type;
        logic [1:0]  src;
        logic [31:0] count;
        logic [31:0] total_bytes;
        logic        size_overflow;
        logic [47:0] source_offset;
        logic [15:0] first_idx;
        logic [31:0] seg_index;
        logic        last_result;
        logic        final_segment;
    } t_desc;

endpackage

/* src/sparse_image_chunk_splitter_core.sv */
// An accepted entry's descriptors pass the classifier slots, the command queue,
// stage 1 and the output register. Throughput: one descriptor per cycle at the output
// while the receiver is ready; an entry holds the classifier until the last of its
// descriptors (0 to 4) enters the queue, as the classifier has a single queue write port.
// Reset: synchronous, active low; clears run state, queue, pipeline and loads register
// defaults (header 12 bytes, 4096-byte blocks, all else zero).
// ----------------------------------------------------------------------------
// Sparse image chunk splitter core
// Splits one sparse-image chunk into chunk descriptors from its list of modified
// block entries; holds the configuration registers.
// ----------------------------------------------------------------------------
module sparse_image_chunk_splitter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sisc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sisc_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [31:0]                        i_block_number,
    input  logic                               i_has_data,
    input  logic                               i_last_entry,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_segment_type,
    output logic [1:0]                         o_data_source,
    output logic [31:0]                        o_block_count,
    output logic [31:0]                        o_total_bytes,
    output logic                               o_size_overflow,
    output logic [47:0]                        o_source_offset,
    output logic [15:0]                        o_first_entry_index,
    output logic [31:0]                        o_segment_index,
    output logic                               o_last_result,
    output logic                               o_final_segment
);
    import sisc_pkg::*;

    t_cfg  r_cfg;
    logic  push;
    t_cmd  push_data;
    logic  full;
    logic  pop;
    t_cmd  pop_data;
    logic  empty;
    t_desc desc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_FIRST_BLOCK: r_cfg.first_block     <= i_cfg_wr_data[31:0];
                CFG_FINAL_BLOCK: r_cfg.final_block     <= i_cfg_wr_data[31:0];
                CFG_CHUNK_KIND:  r_cfg.kind            <= i_cfg_wr_data[1:0];
                CFG_HEADER_LEN:  r_cfg.header_bytes    <= i_cfg_wr_data[7:0];
                CFG_BLOCK_BYTES: r_cfg.bytes_per_block <= i_cfg_wr_data[20:0];
                CFG_DATA_OFFSET: r_cfg.data_offset     <= i_cfg_wr_data[47:0];
                default: begin
                end
            endcase
        end
    end

    // entry classifier
    sisc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_block_number (i_block_number),
        .i_has_data     (i_has_data),
        .i_last_entry   (i_last_entry),
        .o_push         (push),
        .o_push_data    (push_data),
        .i_full         (full)
    );

    // command queue
    sisc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    // size and offset unit
    sisc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_pop_data (pop_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_desc     (desc)
    );

    // descriptor fields
    assign o_segment_type      = desc.seg_type;
    assign o_data_source       = desc.src;
    assign o_block_count       = desc.count;
    assign o_total_bytes       = desc.total_bytes;
    assign o_size_overflow     = desc.size_overflow;
    assign o_source_offset     = desc.source_offset;
    assign o_first_entry_index = desc.first_idx;
    assign o_segment_index     = desc.seg_index;
    assign o_last_result       = desc.last_result;
    assign o_final_segment     = desc.final_segment;

endmodule

/* src/sisc_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short register queue between the classifier and the size/offset unit.
// ----------------------------------------------------------------------------
module sisc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sisc_pkg::t_cmd  i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output sisc_pkg::t_cmd  o_pop_data,
    output logic            o_empty
);
    import sisc_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    // status and read side
    assign o_full     = (r_count == QUEUE_FULL_COUNT);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* src/sisc_front.sv */
// ----------------------------------------------------------------------------
// Entry classifier
// Tracks the open run, turns each entry into up to four descriptor commands
// and feeds them into the queue one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module sisc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sisc_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_block_number,
    input  logic            i_has_data,
    input  logic            i_last_entry,
    output logic            o_push,
    output sisc_pkg::t_cmd  o_push_data,
    input  logic            i_full
);
    import sisc_pkg::*;

    // untouched run in the original chunk's kind
    function automatic t_cmd make_untouched(input logic [1:0] kind, input logic [31:0] count,
                                            input logic [32:0] blocks_in);
        t_cmd c;
        c       = '0;
        c.count = count;
        case (kind)
            SEG_RAW: begin
                c.seg_type  = SEG_RAW;
                c.src       = SRC_ORIGINAL;
                c.blocks_in = blocks_in;
            end
            SEG_FILL: begin
                c.seg_type = SEG_FILL;
                c.src      = SRC_NONE;
            end
            default: begin
                c.seg_type = SEG_SKIP;
                c.src      = SRC_NONE;
            end
        endcase
        return c;
    endfunction

    // entry index reported in 16 bits
    function automatic logic [15:0] idx16(input logic [ENTRY_W-1:0] e);
        logic [ENTRY_W+15:0] w;
        w = {16'd0, e};
        return w[15:0];
    endfunction

    // run of modified entries
    function automatic t_cmd make_run(input logic has_data, input logic [31:0] len,
                                      input logic [ENTRY_W-1:0] first_entry);
        t_cmd c;
        c       = '0;
        c.count = len;
        if (has_data) begin
            c.seg_type  = SEG_RAW;
            c.src       = SRC_ENTRIES;
            c.first_idx = idx16(first_entry);
        end else begin
            c.seg_type = SEG_SKIP;
            c.src      = SRC_NONE;
        end
        return c;
    endfunction

    // run state
    logic               r_started;
    logic               r_run_has_data;
    logic [31:0]        r_run_length;
    logic [ENTRY_W-1:0] r_run_first_entry;
    logic [31:0]        r_prev_block;
    logic [ENTRY_W-1:0] r_entry_cnt;
    logic [31:0]        r_seg_cnt;

    // pending commands of the current transaction
    t_cmd               r_slot [4];
    logic [3:0]         r_mask;

    logic               n_run_has_data;
    logic [31:0]        n_run_length;
    logic [ENTRY_W-1:0] n_run_first_entry;
    logic [ENTRY_W-1:0] n_entry_cnt;
    logic [31:0]        n_seg_cnt;
    logic [3:0]         n_mask;
    t_cmd               n_slot [4];
    logic [31:0]        seg_base [4];
    logic [3:0]         slot_hi;

    logic               accept;
    logic [32:0]        bn_ext;
    logic [32:0]        prev_inc;
    logic               run_grows;
    logic               closes;
    logic               gap;
    logic               lead;
    logic               trail;
    logic [1:0]         sel;
    logic [3:0]         mask_after;

    // classify the offered entry against the open run
    assign bn_ext    = {1'b0, i_block_number};
    assign prev_inc  = {1'b0, r_prev_block} + 33'd1;
    assign run_grows = r_started && (prev_inc == bn_ext) && (i_has_data == r_run_has_data);
    assign closes    = r_started && !run_grows;
    assign gap       = closes && (prev_inc < bn_ext);
    assign lead      = !r_started && (i_cfg.first_block < i_block_number);
    assign trail     = i_last_entry && (i_block_number < i_cfg.final_block);

    // run after this entry
    always_comb begin
        if (run_grows) begin
            n_run_has_data    = r_run_has_data;
            n_run_first_entry = r_run_first_entry;
            n_run_length      = (r_run_length == 32'hFFFF_FFFF) ? r_run_length
                                                                : r_run_length + 32'd1;
        end else begin
            n_run_has_data    = i_has_data;
            n_run_first_entry = r_entry_cnt;
            n_run_length      = 32'd1;
        end
    end

    // entry counter wraps at the list size
    assign n_entry_cnt = (r_entry_cnt == ENTRY_W'(MAX_ENTRIES - 1)) ? '0
                                                                    : r_entry_cnt + 1'b1;

    // descriptor slots: leading or closing run, gap, final run, trailing run
    always_comb begin
        n_mask = {trail, i_last_entry, gap, lead || closes};

        n_slot[0] = lead ? make_untouched(i_cfg.kind, i_block_number - i_cfg.first_block, '0)
                         : make_run(r_run_has_data, r_run_length, r_run_first_entry);
        n_slot[1] = make_untouched(i_cfg.kind, i_block_number - r_prev_block - 32'd1,
                                   {1'b0, r_prev_block - i_cfg.first_block} + 33'd1);
        n_slot[2] = make_run(n_run_has_data, n_run_length, n_run_first_entry);
        n_slot[3] = make_untouched(i_cfg.kind, i_cfg.final_block - i_block_number,
                                   {1'b0, i_block_number - i_cfg.first_block} + 33'd1);

        seg_base[0] = r_seg_cnt;
        seg_base[1] = seg_base[0] + {31'd0, n_mask[0]};
        seg_base[2] = seg_base[1] + {31'd0, n_mask[1]};
        seg_base[3] = seg_base[2] + {31'd0, n_mask[2]};

        slot_hi[3] = n_mask[3];
        slot_hi[2] = n_mask[2] && !n_mask[3];
        slot_hi[1] = n_mask[1] && !(|n_mask[3:2]);
        slot_hi[0] = n_mask[0] && !(|n_mask[3:1]);

        for (int k = 0; k < 4; k++) begin
            n_slot[k].seg_index     = seg_base[k];
            n_slot[k].last_result   = slot_hi[k];
            n_slot[k].final_segment = slot_hi[k] && i_last_entry;
        end

        n_seg_cnt = i_last_entry ? 32'd0 : seg_base[2];
    end

    // lowest pending slot goes out first
    always_comb begin
        sel = 2'd0;
        for (int k = 3; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = 2'(k);
            end
        end
        mask_after = r_mask & ~(4'b0001 << sel);
    end

    assign o_push      = (|r_mask) && !i_full;
    assign o_push_data = r_slot[sel];
    assign o_ready     = i_rst_n && (!(|r_mask) || (o_push && (mask_after == 4'd0)));
    assign accept      = i_valid && o_ready;

    // run state and pending mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started         <= 1'b0;
            r_run_has_data    <= 1'b0;
            r_run_length      <= '0;
            r_run_first_entry <= '0;
            r_prev_block      <= '0;
            r_entry_cnt       <= '0;
            r_seg_cnt         <= '0;
            r_mask            <= '0;
        end else begin
            if (accept) begin
                r_mask    <= n_mask;
                r_seg_cnt <= n_seg_cnt;
                if (i_last_entry) begin
                    r_started         <= 1'b0;
                    r_run_has_data    <= 1'b0;
                    r_run_length      <= '0;
                    r_run_first_entry <= '0;
                    r_prev_block      <= '0;
                    r_entry_cnt       <= '0;
                end else begin
                    r_started         <= 1'b1;
                    r_run_has_data    <= n_run_has_data;
                    r_run_length      <= n_run_length;
                    r_run_first_entry <= n_run_first_entry;
                    r_prev_block      <= i_block_number;
                    r_entry_cnt       <= n_entry_cnt;
                end
            end else if (o_push) begin
                r_mask <= mask_after;
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot <= n_slot;
        end
    end

endmodule

/* src/sisc_back.sv */
// ----------------------------------------------------------------------------
// Size and offset unit
// Two-stage pipeline: block products, then header sum, overflow and offset.
// ----------------------------------------------------------------------------
module sisc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sisc_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    output logic            o_pop,
    input  sisc_pkg::t_cmd  i_pop_data,
    output logic            o_valid,
    input  logic            i_ready,
    output sisc_pkg::t_desc o_desc
);
    import sisc_pkg::*;

    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic [52:0] r_prod_cnt;
    logic [53:0] r_prod_off;
    logic        r_out_valid;
    t_desc       r_out;

    logic        s2_load;
    logic        s1_adv;
    logic        s1_load;
    logic [53:0] payload;
    logic [53:0] total_full;
    logic [47:0] offset;
    t_desc       n_out;

    // stall control
    assign s2_load = !r_out_valid || i_ready;
    assign s1_adv  = r_s1_valid && s2_load;
    assign s1_load = !r_s1_valid || s1_adv;
    assign o_pop   = !i_empty && s1_load;

    // stage 1: block count and block position times block size
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd   <= i_pop_data;
            r_prod_cnt <= {21'd0, i_pop_data.count} * {32'd0, i_cfg.bytes_per_block};
            r_prod_off <= {21'd0, i_pop_data.blocks_in} * {33'd0, i_cfg.bytes_per_block};
        end
    end

    // stage 2: total size, overflow flag, source offset
    always_comb begin
        case (r_s1_cmd.seg_type)
            SEG_RAW:  payload = {1'b0, r_prod_cnt};
            SEG_FILL: payload = {51'd0, FILL_PAYLOAD_BYTES};
            default:  payload = '0;
        endcase
        total_full = {46'd0, i_cfg.header_bytes} + payload;
        offset     = (r_s1_cmd.src == SRC_ORIGINAL) ? i_cfg.data_offset + r_prod_off[47:0]
                                                    : 48'd0;

        n_out.seg_type      = r_s1_cmd.seg_type;
        n_out.src           = r_s1_cmd.src;
        n_out.count         = r_s1_cmd.count;
        n_out.total_bytes   = total_full[31:0];
        n_out.size_overflow = |total_full[53:32];
        n_out.source_offset = offset;
        n_out.first_idx     = r_s1_cmd.first_idx;
        n_out.seg_index     = r_s1_cmd.seg_index;
        n_out.last_result   = r_s1_cmd.last_result;
        n_out.final_segment = r_s1_cmd.final_segment;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= o_pop || (r_s1_valid && !s1_adv);
            r_out_valid <= s1_adv || (r_out_valid && !i_ready);
        end
    end

    assign o_valid = r_out_valid;
    assign o_desc  = r_out;

endmodule

/* src/sisc_checker.sv */
// ----------------------------------------------------------------------------
// Splitter port checker
// Watches the top-level ports for descriptor consistency over time.
// ----------------------------------------------------------------------------
`include "sparse_image_chunk_splitter_core_defines.svh"

module sisc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_segment_type,
    input logic [1:0]  o_data_source,
    input logic [47:0] o_source_offset,
    input logic [15:0] o_first_entry_index,
    input logic        o_last_result,
    input logic        o_final_segment
);
    import sisc_pkg::*;

    logic src_copies;
    logic not_copied;
    logic not_entries;

    // source classes of the offered descriptor
    assign src_copies  = o_valid && (o_data_source inside {SRC_ENTRIES, SRC_ORIGINAL});
    assign not_copied  = o_valid && (o_data_source != SRC_ORIGINAL);
    assign not_entries = o_valid && (o_data_source != SRC_ENTRIES);

    // a stalled descriptor stays offered
    `SISC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "descriptor dropped while stalled")

    // chunk end is always the last descriptor of its transaction
    `SISC_ASSERT_NOW(a_final_is_last, o_valid && o_final_segment, o_last_result, "final not last")

    // payload sources only go with raw chunks
    `SISC_ASSERT_NOW(a_src_raw, src_copies, o_segment_type == SEG_RAW, "source on non-raw chunk")

    // offsets only for copied runs
    `SISC_ASSERT_NOW(a_offset_zero, not_copied, o_source_offset == 48'd0, "stray source offset")

    // entry index only for new-data runs
    `SISC_ASSERT_NOW(a_index_zero, not_entries, o_first_entry_index == 16'd0, "stray entry index")

endmodule

bind sparse_image_chunk_splitter_core sisc_checker u_sisc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_segment_type      (o_segment_type),
    .o_data_source       (o_data_source),
    .o_source_offset     (o_source_offset),
    .o_first_entry_index (o_first_entry_index),
    .o_last_result       (o_last_result),
    .o_final_segment     (o_final_segment)
);

/* test/sisc_desc_checker.sv */
// ----------------------------------------------------------------------------
// Sparse image chunk splitter descriptor checker
// Watches the register port and both channels, works out the descriptors each
// accepted entry must produce and compares every delivered descriptor in order.
// ----------------------------------------------------------------------------
module sisc_desc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sisc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sisc_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                            i_entry_valid,
    input  logic                            i_entry_ready,
    input  logic [31:0]                     i_block_number,
    input  logic                            i_has_data,
    input  logic                            i_last_entry,
    input  logic                            i_desc_valid,
    input  logic                            i_desc_ready,
    input  logic [1:0]                      i_segment_type,
    input  logic [1:0]                      i_data_source,
    input  logic [31:0]                     i_block_count,
    input  logic [31:0]                     i_total_bytes,
    input  logic                            i_size_overflow,
    input  logic [47:0]                     i_source_offset,
    input  logic [15:0]                     i_first_entry_index,
    input  logic [31:0]                     i_segment_index,
    input  logic                            i_last_result,
    input  logic                            i_final_segment,
    output int                              o_mismatch_count,
    output int                              o_descs_due
);
    import sisc_pkg::*;

    // shadow registers and run state
    t_cfg        cfg;
    bit          run_open;
    bit          run_data;
    logic [31:0] run_len;
    logic [15:0] run_first_idx;
    logic [31:0] prev_block;
    logic [15:0] entry_count;
    logic [31:0] seg_count;

    // descriptors of the current entry, and those still owed by the block
    t_desc step_descs[$];
    t_desc descs_due[$];

    task automatic clear_run_state();
        run_open      = 1'b0;
        run_data      = 1'b0;
        run_len       = '0;
        run_first_idx = '0;
        prev_block    = '0;
        entry_count   = '0;
        seg_count     = '0;
    endtask

    // one descriptor with its size worked out from the registers
    task automatic emit_desc(input logic [1:0] seg_type, input logic [1:0] src,
                             input logic [31:0] count, input logic [47:0] offset,
                             input logic [15:0] first_idx);
        t_desc       d;
        logic [63:0] total;
        total = 64'(cfg.header_bytes);
        if (seg_type == SEG_RAW)
            total = total + 64'(count) * 64'(cfg.bytes_per_block);
        else if (seg_type == SEG_FILL)
            total = total + 64'(FILL_PAYLOAD_BYTES);
        d.seg_type      = seg_type;
        d.src           = src;
        d.count         = count;
        d.total_bytes   = total[31:0];
        d.size_overflow = (total > 64'hFFFF_FFFF);
        d.source_offset = offset;
        d.first_idx     = first_idx;
        d.seg_index     = seg_count;
        d.last_result   = 1'b0;
        d.final_segment = 1'b0;
        seg_count       = seg_count + 32'd1;
        step_descs.push_back(d);
    endtask

    // untouched blocks take the kind of the original chunk
    task automatic emit_untouched(input logic [31:0] count, input logic [32:0] blocks_in);
        logic [63:0] offs;
        if (cfg.kind == SEG_RAW) begin
            offs = 64'(cfg.data_offset) + 64'(blocks_in) * 64'(cfg.bytes_per_block);
            emit_desc(SEG_RAW, SRC_ORIGINAL, count, offs[47:0], 16'd0);
        end else if (cfg.kind == SEG_FILL) begin
            emit_desc(SEG_FILL, SRC_NONE, count, 48'd0, 16'd0);
        end else begin
            emit_desc(SEG_SKIP, SRC_NONE, count, 48'd0, 16'd0);
        end
    endtask

    task automatic emit_run();
        if (run_data)
            emit_desc(SEG_RAW, SRC_ENTRIES, run_len, 48'd0, run_first_idx);
        else
            emit_desc(SEG_SKIP, SRC_NONE, run_len, 48'd0, 16'd0);
    endtask

    // descriptors caused by one modified entry
    task automatic split_entry(input logic [31:0] bn, input logic data, input logic last);
        logic [15:0] idx;
        idx = entry_count;
        step_descs.delete();
        if (!run_open) begin
            // leading untouched run only when the chunk starts below the entry
            if (cfg.first_block < bn)
                emit_untouched(bn - cfg.first_block, 33'd0);
            run_open      = 1'b1;
            run_data      = data;
            run_len       = 32'd1;
            run_first_idx = idx;
        end else if ({1'b0, prev_block} + 33'd1 == {1'b0, bn} && data == run_data) begin
            if (run_len != 32'hFFFF_FFFF)
                run_len = run_len + 32'd1;
        end else begin
            // close the run, plus the untouched gap when the entry jumps ahead
            emit_run();
            if ({1'b0, prev_block} + 33'd1 < {1'b0, bn})
                emit_untouched(bn - prev_block - 32'd1,
                               {1'b0, prev_block - cfg.first_block} + 33'd1);
            run_data      = data;
            run_len       = 32'd1;
            run_first_idx = idx;
        end
        prev_block  = bn;
        entry_count = entry_count + 16'd1;

        // end of list: close the run and add the trailing untouched run
        if (last) begin
            emit_run();
            if (bn < cfg.final_block)
                emit_untouched(cfg.final_block - bn, {1'b0, bn - cfg.first_block} + 33'd1);
            step_descs[step_descs.size()-1].final_segment = 1'b1;
            clear_run_state();
        end
        if (step_descs.size() > 0)
            step_descs[step_descs.size()-1].last_result = 1'b1;
        foreach (step_descs[k])
            descs_due.push_back(step_descs[k]);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            o_mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // compare delivered descriptors, then predict from the accepted entry
    always @(posedge i_clk) begin
        t_desc want;
        if (!i_rst_n) begin
            cfg = CFG_RESET;
            clear_run_state();
            descs_due.delete();
        end else begin
            if (i_desc_valid && i_desc_ready) begin
                if (descs_due.size() == 0) begin
                    o_mismatch_count++;
                    $display("%0t: descriptor expected none actual segment_index %0h",
                             $time, i_segment_index);
                end else begin
                    want = descs_due.pop_front();
                    check_field("segment_type", 64'(want.seg_type), 64'(i_segment_type));
                    check_field("data_source", 64'(want.src), 64'(i_data_source));
                    check_field("block_count", 64'(want.count), 64'(i_block_count));
                    check_field("total_bytes", 64'(want.total_bytes), 64'(i_total_bytes));
                    check_field("size_overflow", 64'(want.size_overflow),
                                64'(i_size_overflow));
                    check_field("source_offset", 64'(want.source_offset),
                                64'(i_source_offset));
                    check_field("first_entry_index", 64'(want.first_idx),
                                64'(i_first_entry_index));
                    check_field("segment_index", 64'(want.seg_index), 64'(i_segment_index));
                    check_field("last_result", 64'(want.last_result), 64'(i_last_result));
                    check_field("final_segment", 64'(want.final_segment),
                                64'(i_final_segment));
                end
            end
            if (i_entry_valid && i_entry_ready)
                split_entry(i_block_number, i_has_data, i_last_entry);
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_FIRST_BLOCK: cfg.first_block     = i_cfg_wr_data[31:0];
                    CFG_FINAL_BLOCK: cfg.final_block     = i_cfg_wr_data[31:0];
                    CFG_CHUNK_KIND:  cfg.kind            = i_cfg_wr_data[1:0];
                    CFG_HEADER_LEN:  cfg.header_bytes    = i_cfg_wr_data[7:0];
                    CFG_BLOCK_BYTES: cfg.bytes_per_block = i_cfg_wr_data[20:0];
                    CFG_DATA_OFFSET: cfg.data_offset     = i_cfg_wr_data[47:0];
                    default: ;
                endcase
            end
        end
        o_descs_due = descs_due.size();
    end

endmodule

/* test/tb_sparse_image_chunk_splitter_core.sv */
// ----------------------------------------------------------------------------
// Sparse image chunk splitter core testbench
// Drives entry lists under many register settings, directed corner lists first
// and then random lists, with random stalls on both channels; the checker
// beside the block compares every descriptor and reports the mismatch count.
// ----------------------------------------------------------------------------
module tb_sparse_image_chunk_splitter_core;
    import sisc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned RANDOM_ITEMS = 215;
    localparam int unsigned QUIET_AFTER  = 180;
    localparam int unsigned SETTLE       = 12;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [31:0]           i_block_number;
    logic                  i_has_data;
    logic                  i_last_entry;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_segment_type;
    logic [1:0]            o_data_source;
    logic [31:0]           o_block_count;
    logic [31:0]           o_total_bytes;
    logic                  o_size_overflow;
    logic [47:0]           o_source_offset;
    logic [15:0]           o_first_entry_index;
    logic [31:0]           o_segment_index;
    logic                  o_last_result;
    logic                  o_final_segment;

    int          mismatch_count;
    int          descs_due;
    int unsigned cycle_count;
    int unsigned random_items;
    bit          quiet_tail;
    bit          stall_request;
    t_cfg        cur_cfg;

    sparse_image_chunk_splitter_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_block_number      (i_block_number),
        .i_has_data          (i_has_data),
        .i_last_entry        (i_last_entry),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_segment_type      (o_segment_type),
        .o_data_source       (o_data_source),
        .o_block_count       (o_block_count),
        .o_total_bytes       (o_total_bytes),
        .o_size_overflow     (o_size_overflow),
        .o_source_offset     (o_source_offset),
        .o_first_entry_index (o_first_entry_index),
        .o_segment_index     (o_segment_index),
        .o_last_result       (o_last_result),
        .o_final_segment     (o_final_segment)
    );

    sisc_desc_checker i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_entry_valid       (i_valid),
        .i_entry_ready       (o_ready),
        .i_block_number      (i_block_number),
        .i_has_data          (i_has_data),
        .i_last_entry        (i_last_entry),
        .i_desc_valid        (o_valid),
        .i_desc_ready        (i_ready),
        .i_segment_type      (o_segment_type),
        .i_data_source       (o_data_source),
        .i_block_count       (o_block_count),
        .i_total_bytes       (o_total_bytes),
        .i_size_overflow     (o_size_overflow),
        .i_source_offset     (o_source_offset),
        .i_first_entry_index (o_first_entry_index),
        .i_segment_index     (o_segment_index),
        .i_last_result       (o_last_result),
        .i_final_segment     (o_final_segment),
        .o_mismatch_count    (mismatch_count),
        .o_descs_due         (descs_due)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sparse_image_chunk_splitter_core: mismatch");
            $finish;
        end
    end

    // descriptor receiver: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (stall_request) begin
                stall_request = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= addr;
        i_cfg_wr_data <= data;
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(CFG_FIRST_BLOCK, CFG_DATA_W'(c.first_block));
        write_reg(CFG_FINAL_BLOCK, CFG_DATA_W'(c.final_block));
        write_reg(CFG_CHUNK_KIND, CFG_DATA_W'(c.kind));
        write_reg(CFG_HEADER_LEN, CFG_DATA_W'(c.header_bytes));
        write_reg(CFG_BLOCK_BYTES, CFG_DATA_W'(c.bytes_per_block));
        write_reg(CFG_DATA_OFFSET, CFG_DATA_W'(c.data_offset));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    // offer one entry and hold it until the block accepts it
    task automatic send_entry(input logic [31:0] bn, input logic data, input logic last);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_block_number <= bn;
        i_has_data     <= data;
        i_last_entry   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic pause_entries(input int unsigned cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (descs_due != 0) @(negedge i_clk);
    endtask

    // all descriptors in, plus time for an entry that owes none
    task automatic drain_block();
        wait_results();
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic make_random_cfg(output t_cfg c);
        case ($urandom_range(0, 3))
            0: c.first_block = 32'd0;
            1: c.first_block = $urandom;
            2: c.first_block = 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: c.first_block = $urandom_range(0, 1000);
        endcase
        if ($urandom_range(0, 4) == 0)
            c.final_block = $urandom;
        else
            c.final_block = c.first_block + $urandom_range(0, 150);
        c.kind = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: c.header_bytes = 8'd0;
            1: c.header_bytes = 8'd255;
            default: c.header_bytes = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
            0: c.bytes_per_block = 21'd1;
            1: c.bytes_per_block = 21'd1048576;
            2: c.bytes_per_block = DEFAULT_BLOCK_BYTES;
            3: c.bytes_per_block = 21'd0;
            4: c.bytes_per_block = 21'h1F_FFFF;
            default: c.bytes_per_block = 21'($urandom_range(1, 1048576));
        endcase
        case ($urandom_range(0, 3))
            0: c.data_offset = 48'd0;
            1: c.data_offset = 48'hFFFF_FFFF_FFFF;
            default: c.data_offset = 48'({$urandom, $urandom});
        endcase
    endtask

    // mostly ascending lists near the chunk start, some noisy ones
    task automatic send_random_chunk();
        int unsigned len;
        bit          noisy;
        logic [31:0] bn;
        logic        data;
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 12);
        noisy = ($urandom_range(0, 4) == 0);
        bn    = cur_cfg.first_block + $urandom_range(0, 4);
        if ($urandom_range(0, 5) == 0)
            bn = cur_cfg.first_block - 32'd1;
        data = 1'($urandom_range(0, 1));
        for (int unsigned n = 0; n < len; n++) begin
            if (n > 0) begin
                if (noisy) begin
                    case ($urandom_range(0, 4))
                        0: bn = $urandom;
                        1: bn = bn - $urandom_range(0, 3);
                        2: bn = 32'hFFFF_FFFF;
                        3: bn = 32'd0;
                        default: bn = bn + 32'd1;
                    endcase
                    data = 1'($urandom_range(0, 1));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: bn = bn + 32'd1;
                        6, 7, 8: bn = bn + $urandom_range(2, 6);
                        default: bn = bn + $urandom_range(7, 1000);
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        data = ~data;
                end
            end
            if (!quiet_tail && $urandom_range(0, 3) == 0)
                pause_entries($urandom_range(1, 11));
            send_entry(bn, data, n == len - 1);
        end
        random_items += len;
    endtask

    // stimulus and verdict
    initial begin
        t_cfg c;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wr_data  = '0;
        i_valid        = 1'b0;
        i_block_number = '0;
        i_has_data     = 1'b0;
        i_last_entry   = 1'b0;
        quiet_tail     = 1'b0;
        stall_request  = 1'b0;
        random_items   = 0;
        cur_cfg        = CFG_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single entry list at block zero, default sizes
        apply_config('{first_block: 32'd0, final_block: 32'd0, kind: SEG_RAW,
                       header_bytes: 8'd12, bytes_per_block: 21'd4096, data_offset: 48'd0});
        send_entry(32'd0, 1'b1, 1'b1);
        drain_block();

        // leading run, extension, kind change, gaps and trailing run of raw copy
        apply_config('{first_block: 32'd10, final_block: 32'd40, kind: SEG_RAW,
                       header_bytes: 8'd12, bytes_per_block: 21'd4096,
                       data_offset: 48'h1000});
        send_entry(32'd12, 1'b1, 1'b0);
        send_entry(32'd13, 1'b1, 1'b0);
        send_entry(32'd14, 1'b0, 1'b0);
        wait_results();
        send_entry(32'd20, 1'b0, 1'b0);
        send_entry(32'd21, 1'b1, 1'b0);
        send_entry(32'd25, 1'b1, 1'b0);
        send_entry(32'd30, 1'b1, 1'b1);
        drain_block();

        // fill chunk: out of order entry, block number wrap, huge raw sizes
        apply_config('{first_block: 32'd0, final_block: 32'hFFFF_FFFF, kind: SEG_FILL,
                       header_bytes: 8'd255, bytes_per_block: 21'd1048576,
                       data_offset: 48'hFFFF_FFFF_FFFF});
        send_entry(32'd5, 1'b1, 1'b0);
        send_entry(32'd3, 1'b0, 1'b0);
        send_entry(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_entry(32'd0, 1'b1, 1'b1);
        drain_block();

        // unused kind code, entries outside the chunk, zero block size
        apply_config('{first_block: 32'd100, final_block: 32'd50, kind: 2'd3,
                       header_bytes: 8'd0, bytes_per_block: 21'd0,
                       data_offset: 48'h1234});
        send_entry(32'd20, 1'b0, 1'b0);
        send_entry(32'd200, 1'b1, 1'b1);
        drain_block();

        // raw copy runs whose size overflows and whose offset wraps
        apply_config('{first_block: 32'd0, final_block: 32'hFFFF_FFFF, kind: SEG_RAW,
                       header_bytes: 8'd12, bytes_per_block: 21'd1048576,
                       data_offset: 48'hFFFF_FFFF_FFFF});
        send_entry(32'h0001_0000, 1'b1, 1'b1);
        drain_block();

        // don't care chunk with a deleted entry
        apply_config('{first_block: 32'd0, final_block: 32'd20, kind: SEG_SKIP,
                       header_bytes: 8'd12, bytes_per_block: 21'd4096, data_offset: 48'd0});
        send_entry(32'd5, 1'b0, 1'b1);
        drain_block();

        // receiver holds off while alternating entries keep the block busy
        apply_config('{first_block: 32'd0, final_block: 32'd100, kind: SEG_FILL,
                       header_bytes: 8'd12, bytes_per_block: 21'd4096, data_offset: 48'd0});
        stall_request = 1'b1;
        for (int unsigned n = 0; n < 24; n++)
            send_entry(32'd1 + n, n[0], n == 23);
        drain_block();

        // random lists under random settings
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= QUIET_AFTER)
                quiet_tail = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                drain_block();
                make_random_cfg(c);
                apply_config(c);
            end
            send_random_chunk();
        end

        drain_block();
        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("sparse_image_chunk_splitter_core: match");
        else
            $display("sparse_image_chunk_splitter_core: mismatch");
        $finish;
    end

endmodule
